>>> sv/assert_macros.svh
// Assertion macros shared by the list engine modules.
// Included by every file that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/olte_pkg.sv
// Types and codes of the ordered list engine.
// No dependencies; used by the controller, the datapath and the top level.
package olte_pkg;

  localparam logic [2:0] REQ_GET    = 3'd0;
  localparam logic [2:0] REQ_LOCATE = 3'd1;
  localparam logic [2:0] REQ_INSERT = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_POS = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] position;
    logic [7:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] elem_out;
    logic [6:0] found_pos;
    logic [6:0] list_length;
    logic       is_empty;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_GET_WAIT,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_INS_PUT,
    ST_DEL_HEAD,
    ST_SHIFT_DN
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_POS,
    RD_TOP,
    RD_ZERO,
    RD_NEXT,
    RD_PREV
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_VAL
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;
    rd_sel_t    rd_sel;
    wr_sel_t    wr_sel;
    cnt_op_t    cnt_op;
    logic       cap_elem;
    logic       cap_found;
    logic       finish;
    logic [1:0] status;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] kind;
    logic       in_range;
    logic       ins_range;
    logic       full;
    logic       empty;
    logic       append;
    logic       match;
    logic       last;
    logic       at_pos;
  } dp_stat_t;

endpackage

>>> sv/olte_ctrl.sv
// Request sequencer of the ordered list engine.
// Depends on olte_pkg and assert_macros.svh; drives the datapath commands.
`include "assert_macros.svh"

module olte_ctrl
  import olte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.rd_sel    = RD_NONE;
    cmd.wr_sel    = WR_NONE;
    cmd.cnt_op    = CNT_HOLD;
    cmd.cap_elem  = 1'b0;
    cmd.cap_found = 1'b0;
    cmd.finish    = 1'b0;
    cmd.status    = STAT_OK;
    busy          = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.kind)
          REQ_GET: begin
            if (!stat.in_range) begin
              cmd.finish = 1'b1;
              cmd.status = STAT_BAD_POS;
              state_nxt  = ST_IDLE;
            end else begin
              cmd.rd_sel = RD_POS;
              state_nxt  = ST_GET_WAIT;
            end
          end
          REQ_LOCATE: begin
            if (stat.empty) begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end else begin
              cmd.rd_sel = RD_ZERO;
              state_nxt  = ST_SCAN;
            end
          end
          REQ_INSERT: begin
            if (!stat.ins_range) begin
              cmd.finish = 1'b1;
              cmd.status = STAT_BAD_POS;
              state_nxt  = ST_IDLE;
            end else if (stat.full) begin
              cmd.finish = 1'b1;
              cmd.status = STAT_FULL;
              state_nxt  = ST_IDLE;
            end else if (stat.append) begin
              state_nxt = ST_INS_PUT;
            end else begin
              cmd.rd_sel = RD_TOP;
              state_nxt  = ST_SHIFT_UP;
            end
          end
          REQ_DELETE: begin
            if (!stat.in_range) begin
              cmd.finish = 1'b1;
              cmd.status = STAT_BAD_POS;
              state_nxt  = ST_IDLE;
            end else begin
              cmd.rd_sel = RD_POS;
              state_nxt  = ST_DEL_HEAD;
            end
          end
          REQ_CLEAR: begin
            cmd.cnt_op = CNT_CLR;
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
          default: begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        endcase
      end
      ST_GET_WAIT: begin
        cmd.cap_elem = 1'b1;
        cmd.finish   = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_SCAN: begin
        // compare the entry that just arrived, fetch the next one meanwhile
        if (stat.match) begin
          cmd.cap_found = 1'b1;
          cmd.finish    = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (stat.last) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.rd_sel = RD_NEXT;
        end
      end
      ST_SHIFT_UP: begin
        cmd.wr_sel = WR_UP;
        if (stat.at_pos) begin
          state_nxt = ST_INS_PUT;
        end else begin
          cmd.rd_sel = RD_PREV;
        end
      end
      ST_INS_PUT: begin
        cmd.wr_sel = WR_VAL;
        cmd.cnt_op = CNT_INC;
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_DEL_HEAD: begin
        cmd.cap_elem = 1'b1;
        if (stat.last) begin
          cmd.cnt_op = CNT_DEC;
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.rd_sel = RD_NEXT;
          state_nxt  = ST_SHIFT_DN;
        end
      end
      ST_SHIFT_DN: begin
        cmd.wr_sel = WR_DOWN;
        if (stat.last) begin
          cmd.cnt_op = CNT_DEC;
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.rd_sel = RD_NEXT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `ASSERT_NXT(a_accept_decode, clk, rst_n, start && !busy, state_r == ST_DECODE, "accepted beat did not reach decode")
  `ASSERT_IMP(a_idle_quiet, clk, rst_n, state_r == ST_IDLE, cmd.wr_sel == WR_NONE && cmd.cnt_op == CNT_HOLD, "store or count touched while idle")
  `ASSERT_NXT(a_finish_idle, clk, rst_n, cmd.finish, state_r == ST_IDLE, "sequencer kept running after finish")

endmodule

>>> sv/olte_dp.sv
// Datapath of the ordered list engine: element store, count, pointer, result.
// Depends on olte_pkg and assert_macros.svh; steered by olte_ctrl.
`include "assert_macros.svh"

module olte_dp
  import olte_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > 7) ? CW : 7) + 1;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  logic [7:0] mem [CAPACITY];

  in_item_t        req_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   idx_r;
  logic [7:0]      rd_data_r;
  logic [7:0]      elem_r, elem_nxt;
  logic [6:0]      found_r, found_nxt;
  logic            out_valid_r;
  out_item_t       out_r;

  logic [XW-1:0]   pos_x, cnt_x, pos_m1_x;
  logic [AW-1:0]   pos_m1, cnt_m1, rd_addr, wr_addr;
  logic [CW-1:0]   cnt_m1_w, idx_p1;
  logic            rd_en, wr_en;
  logic [7:0]      wr_data;

  assign pos_x    = XW'(req_r.position);
  assign cnt_x    = XW'(count_r);
  assign pos_m1_x = pos_x - XW'(1);
  assign pos_m1   = pos_m1_x[AW-1:0];
  assign cnt_m1_w = count_r - CW'(1);
  assign cnt_m1   = cnt_m1_w[AW-1:0];
  assign idx_p1   = CW'(idx_r) + CW'(1);

  always_comb begin
    stat.kind      = req_r.req_type;
    stat.in_range  = (req_r.position != 7'd0) && (pos_x <= cnt_x);
    stat.ins_range = (req_r.position != 7'd0) && (pos_x <= cnt_x + XW'(1));
    stat.full      = (count_r == CapC);
    stat.empty     = (count_r == '0);
    stat.append    = (pos_x == cnt_x + XW'(1));
    stat.match     = (rd_data_r == req_r.elem_value);
    stat.last      = (idx_p1 == count_r);
    stat.at_pos    = (idx_r == pos_m1);
  end

  always_comb begin
    rd_en   = (cmd.rd_sel != RD_NONE);
    rd_addr = idx_r;
    case (cmd.rd_sel)
      RD_POS:  rd_addr = pos_m1;
      RD_TOP:  rd_addr = cnt_m1;
      RD_ZERO: rd_addr = '0;
      RD_NEXT: rd_addr = idx_r + AW'(1);
      RD_PREV: rd_addr = idx_r - AW'(1);
      default: rd_addr = idx_r;
    endcase
  end

  always_comb begin
    wr_en   = (cmd.wr_sel != WR_NONE);
    wr_addr = idx_r;
    wr_data = rd_data_r;
    case (cmd.wr_sel)
      WR_UP:   wr_addr = idx_r + AW'(1);
      WR_DOWN: wr_addr = idx_r - AW'(1);
      WR_VAL: begin
        wr_addr = pos_m1;
        wr_data = req_r.elem_value;
      end
      default: wr_addr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      idx_r     <= rd_addr;
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: count_nxt = count_r + CW'(1);
      CNT_DEC: count_nxt = count_r - CW'(1);
      CNT_CLR: count_nxt = '0;
      default: count_nxt = count_r;
    endcase
  end

  always_comb begin
    elem_nxt  = elem_r;
    found_nxt = found_r;
    if (cmd.load) begin
      elem_nxt  = 8'd0;
      found_nxt = 7'd0;
    end
    if (cmd.cap_elem) begin
      elem_nxt = rd_data_r;
    end
    if (cmd.cap_found) begin
      found_nxt = 7'(idx_p1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    elem_r  <= elem_nxt;
    found_r <= found_nxt;
    if (cmd.finish) begin
      out_r.status      <= cmd.status;
      out_r.elem_out    <= elem_nxt;
      out_r.found_pos   <= found_nxt;
      out_r.list_length <= 7'(count_nxt);
      out_r.is_empty    <= (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_r <= CapC, "element count above capacity")
  `ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid_r, !out_valid_r, "result strobe held two cycles")
  `ASSERT_IMP(a_write_in_list, clk, rst_n, wr_en, CW'(wr_addr) <= count_r, "store write beyond list end")

endmodule

>>> sv/ordered_list_table_engine.sv
// Top level of the ordered list engine: sequencer plus store datapath.
// Depends on olte_pkg, olte_ctrl and olte_dp.
//
//  channel   handshake          payload              beat taken when
//  input     start / busy       in_data  (in_item_t)  start && !busy at clk rise
//  result    out_valid strobe   out_data (out_item_t) out_valid at clk rise
//
// With p the position: get reads the entry at p, clear empties the list,
// locate scans from the head for the first match, insert moves the entries
// from p up, delete those above p down. Shifts and scans move one entry per
// cycle through the single-port read and write of the element store.
// A new request is taken in the cycle the previous result is strobed.
// Reset clears the count and the sequencer; the store needs no clearing pass.
// The receiver cannot stall: each result stands for exactly one cycle.
module ordered_list_table_engine
  import olte_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  olte_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  olte_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
